### src/lcfc_pkg.sv
// ----------------------------------------------------------------------------
// lcfc_pkg
// Types, constants and the byte-wide CRC-32 update shared by the framed
// stream checker.
// ----------------------------------------------------------------------------
package lcfc_pkg;

    // Width of the payload length counter.
    localparam int LEN_BITS = 20;
    localparam int MAXLEN_BITS = 20;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam int BITS_PER_BYTE = 8;

    // Header is eight bytes: length, then CRC.
    localparam logic [2:0] HDR_LAST_IDX = 3'd7;
    localparam logic [2:0] HDR_LEN_BYTES = 3'd4;

    // Frame verdict codes.
    localparam logic [1:0] STATUS_MID = 2'd0;
    localparam logic [1:0] STATUS_OK = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic {
        PHASE_HEADER = 1'b0,
        PHASE_PAYLOAD = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       carries_byte;
        logic       is_last;
        logic [1:0] frame_status;
    } out_item_t;

    // Reflected CRC-32 over one byte, unrolled into XOR logic.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < BITS_PER_BYTE; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### src/length_crc32_frame_checker.sv
// ----------------------------------------------------------------------------
// length_crc32_frame_checker
// Checks length-prefixed frames (4-byte length, 4-byte CRC-32, payload),
// passes payload bytes on and tags the last one with the frame verdict.
//
//   channel    direction  handshake                  payload
//   byte_*     in         byte_valid / byte_stall    in_item_t
//   res_*      out        res_valid / res_stall      out_item_t
//   apb        in/out     psel penable pwrite pready max_payload
//
// One byte per cycle sustained while res_stall stays low; a beat is held
// in the input register and then moves into the result register.
// The CRC update is one byte-wide XOR network between those registers.
// Reset puts the parser in header hunting with max_payload all ones.
// A stall on the result side holds the result register, and the input
// register fills behind it before byte_stall rises.
// ----------------------------------------------------------------------------
module length_crc32_frame_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_valid,
    output logic                             byte_stall,
    input  lcfc_pkg::in_item_t               byte_data,
    output logic                             res_valid,
    input  logic                             res_stall,
    output lcfc_pkg::out_item_t              res_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lcfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic                             in_valid_reg, in_valid_next;
    lcfc_pkg::in_item_t               in_item_reg, in_item_next;
    logic                             res_valid_reg, res_valid_next;
    lcfc_pkg::out_item_t              res_reg, res_next;
    logic                             step;
    logic                             produce;
    lcfc_pkg::out_item_t              result;
    logic [lcfc_pkg::MAXLEN_BITS-1:0] max_payload;

    lcfc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_payload (max_payload)
    );

    lcfc_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .max_payload (max_payload),
        .produce     (produce),
        .result      (result)
    );

    // Advance the held beat whenever the result register is free or draining.
    assign step       = in_valid_reg && (!res_valid_reg || !res_stall);
    assign byte_stall = in_valid_reg && !step;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (byte_valid && !byte_stall)
        begin
            in_valid_next = 1'b1;
            in_item_next  = byte_data;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        if (step)
        begin
            res_valid_next = produce;
            res_next       = result;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

### src/lcfc_cfg.sv
// ----------------------------------------------------------------------------
// lcfc_cfg
// APB-style register file holding the maximum payload length.
// ----------------------------------------------------------------------------
module lcfc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcfc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [lcfc_pkg::MAXLEN_BITS-1:0]  max_payload
);

    logic [lcfc_pkg::MAXLEN_BITS-1:0] max_payload_reg;
    logic [lcfc_pkg::MAXLEN_BITS-1:0] max_payload_next;
    logic                             sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[lcfc_pkg::APB_ADDR_W-1:2] == lcfc_pkg::REG_MAX_PAYLOAD);

    always_comb
    begin
        max_payload_next = max_payload_reg;
        if (psel && penable && pwrite && sel_max)
        begin
            max_payload_next = pwdata[lcfc_pkg::MAXLEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= '1;
        end
        else
        begin
            max_payload_reg <= max_payload_next;
        end
    end

    assign prdata      = sel_max ? 32'(max_payload_reg) : 32'd0;
    assign max_payload = max_payload_reg;

endmodule

### src/lcfc_parse.sv
// ----------------------------------------------------------------------------
// lcfc_parse
// Frame state and combinational step logic: header collection, length check,
// payload CRC update and verdict.
// ----------------------------------------------------------------------------
module lcfc_parse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  lcfc_pkg::in_item_t                item,
    input  logic [lcfc_pkg::MAXLEN_BITS-1:0]  max_payload,
    output logic                              produce,
    output lcfc_pkg::out_item_t               result
);

    lcfc_pkg::phase_t               phase_reg, phase_next;
    logic [2:0]                     hdr_idx_reg, hdr_idx_next;
    logic [31:0]                    frame_len_reg, frame_len_next;
    logic [31:0]                    exp_crc_reg, exp_crc_next;
    logic [31:0]                    crc_reg, crc_next;
    logic [lcfc_pkg::LEN_BITS-1:0]  left_reg, left_next;

    lcfc_pkg::phase_t               cur_phase;
    logic [2:0]                     cur_idx;
    logic [31:0]                    limit;
    logic [31:0]                    crc_upd;
    logic [lcfc_pkg::LEN_BITS-1:0]  left_dec;

    // Limit is the smaller of the register and the counter range.
    assign limit = (32'(max_payload) < lcfc_pkg::LEN_MASK) ? 32'(max_payload)
                                                          : lcfc_pkg::LEN_MASK;
    assign crc_upd  = lcfc_pkg::crc_byte(crc_reg, item.data_byte);
    assign left_dec = left_reg - 1'b1;

    always_comb
    begin
        cur_phase      = item.restart ? lcfc_pkg::PHASE_HEADER : phase_reg;
        cur_idx        = item.restart ? 3'd0 : hdr_idx_reg;
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        frame_len_next = frame_len_reg;
        exp_crc_next   = exp_crc_reg;
        crc_next       = crc_reg;
        left_next      = left_reg;
        produce        = 1'b0;
        result         = '0;

        if (step)
        begin
            if (cur_phase == lcfc_pkg::PHASE_HEADER)
            begin
                phase_next   = lcfc_pkg::PHASE_HEADER;
                hdr_idx_next = cur_idx + 3'd1;
                if (cur_idx < lcfc_pkg::HDR_LEN_BYTES)
                begin
                    frame_len_next = {frame_len_reg[23:0], item.data_byte};
                end
                else
                begin
                    exp_crc_next = {exp_crc_reg[23:0], item.data_byte};
                end

                if (cur_idx == lcfc_pkg::HDR_LAST_IDX)
                begin
                    if (frame_len_reg > limit)
                    begin
                        produce             = 1'b1;
                        result.is_last      = 1'b1;
                        result.frame_status = lcfc_pkg::STATUS_TOO_LONG;
                    end
                    else if (frame_len_reg == 32'd0)
                    begin
                        produce             = 1'b1;
                        result.is_last      = 1'b1;
                        result.frame_status = (exp_crc_next == 32'd0)
                                              ? lcfc_pkg::STATUS_OK
                                              : lcfc_pkg::STATUS_CRC_ERR;
                    end
                    else
                    begin
                        left_next  = frame_len_reg[lcfc_pkg::LEN_BITS-1:0];
                        crc_next   = lcfc_pkg::CRC_INIT;
                        phase_next = lcfc_pkg::PHASE_PAYLOAD;
                    end
                end
            end
            else
            begin
                crc_next            = crc_upd;
                left_next           = left_dec;
                produce             = 1'b1;
                result.payload_byte = item.data_byte;
                result.carries_byte = 1'b1;
                if (left_dec == '0)
                begin
                    phase_next          = lcfc_pkg::PHASE_HEADER;
                    hdr_idx_next        = 3'd0;
                    result.is_last      = 1'b1;
                    result.frame_status = (~crc_upd == exp_crc_reg)
                                          ? lcfc_pkg::STATUS_OK
                                          : lcfc_pkg::STATUS_CRC_ERR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcfc_pkg::PHASE_HEADER;
            hdr_idx_reg   <= 3'd0;
            frame_len_reg <= 32'd0;
            exp_crc_reg   <= 32'd0;
            crc_reg       <= lcfc_pkg::CRC_INIT;
            left_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            frame_len_reg <= frame_len_next;
            exp_crc_reg   <= exp_crc_next;
            crc_reg       <= crc_next;
            left_reg      <= left_next;
        end
    end

endmodule
